// ===== rtl/core/dbp_pkg.sv =====
package dbp_pkg;

   localparam int MAX_LINE = 1024;
   localparam int LEN_W    = $clog2(MAX_LINE + 1);

   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_UPPER_C = 8'd67;
   localparam logic [7:0] CH_UPPER_F = 8'd70;
   localparam logic [7:0] CH_BSLASH = 8'd92;

   typedef enum logic [1:0] {
      KIND_PATTERN = 2'd0,
      KIND_DESC    = 2'd1,
      KIND_REPORT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_ENTRY = 2'd0,
      ST_BLANK = 2'd1,
      ST_ERROR = 2'd2,
      ST_LONG  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_LEAD        = 4'd0,
      PH_COMMENT     = 4'd1,
      PH_PAT         = 4'd2,
      PH_AFTER_PAT   = 4'd3,
      PH_NUM         = 4'd4,
      PH_BEFORE_UNIT = 4'd5,
      PH_UNIT_SEEN   = 4'd6,
      PH_BEFORE_DESC = 4'd7,
      PH_DESC        = 4'd8,
      PH_TAIL        = 4'd9,
      PH_ERR         = 4'd10,
      PH_LONG        = 4'd11
   } phase_type;

   typedef struct packed {
      logic         unit_is_fahrenheit;
      logic [15:0]  attr_number;
      status_type   line_status;
      logic [7:0]   string_byte;
      kind_type     kind;
   } rsp_item_type;

   // status a line gets if its content ends in this phase
   function automatic status_type end_status(input phase_type ph);
      status_type st;
      case (ph)
         PH_LEAD, PH_COMMENT: st = ST_BLANK;
         PH_TAIL:             st = ST_ENTRY;
         PH_LONG:             st = ST_LONG;
         default:             st = ST_ERROR;
      endcase
      return st;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// ===== rtl/core/drive_db_line_parser.sv =====
// Text database line parser. One byte enters per cycle on req_ while the
// output is not stalled: an input register holds each byte taken and feeds
// a combinational parse step whose result lands in an output register, so the
// block sustains one byte per clock while rsp_tready stays high. Quoted
// pattern and description bytes come out raw (escapes kept) with tuser
// telling which string they belong to; every newline yields one report item
// carrying the line status, and for a valid entry its attribute number
// (modulo 65536) and unit. A NUL ends a line's content; a line reaching
// 1024 bytes before its newline is reported as too long. rsp_tvalid is the
// output register's valid flag, set when the parse step of a byte runs and
// yields an item.
module drive_db_line_parser
   import dbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] string_byte, [9:8] line_status, [25:10] attr_number,
   // [26] unit_is_fahrenheit, [31:27] zero
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   logic         in_v_ff, in_v_in;
   logic [7:0]   in_byte_ff;
   logic         proceed;
   logic         out_full;
   logic         res_valid;
   rsp_item_type res;
   rsp_item_type out_item;

   assign proceed    = in_v_ff && (!out_full || rsp_tready);
   assign req_tready = !in_v_ff || proceed;
   assign in_v_in    = (req_tvalid && req_tready) || (in_v_ff && !proceed);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   dbp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (proceed),
      .text_byte (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   dbp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (proceed && res_valid),
      .load_item (res),
      .take      (rsp_tready),
      .full      (out_full),
      .item      (out_item)
   );

   assign rsp_tvalid = out_full;
   assign rsp_tuser  = out_item.kind;
   assign rsp_tdata  = {5'd0, out_item.unit_is_fahrenheit, out_item.attr_number,
                        out_item.line_status, out_item.string_byte};

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !proceed |=> in_v_ff && $stable(in_byte_ff))
      else $error("input register lost or changed a stalled item");

   a_nl_report: assert property (@(posedge clock) disable iff (reset)
      proceed && in_byte_ff == CH_NL |=> rsp_tvalid && rsp_tuser == KIND_REPORT)
      else $error("newline did not produce a report");

   a_str_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_REPORT |-> rsp_tdata[31:8] == 24'd0)
      else $error("string item carries report fields");

endmodule

// ===== rtl/core/dbp_parser.sv =====
module dbp_parser
   import dbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  logic [7:0]   text_byte,
   output logic         res_valid,
   output rsp_item_type res
);

   phase_type         phase_ff, phase_in;
   logic              esc_ff, esc_in;
   logic [15:0]       acc_ff, acc_in;
   logic              unit_ff, unit_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic [LEN_W-1:0]  len_inc;
   logic              is_nl;
   logic              too_long;
   logic              active;
   logic [15:0]       digit;
   status_type        st_now;

   assign len_inc  = len_ff + LEN_W'(1);
   assign is_nl    = (text_byte == CH_NL);
   assign too_long = (len_inc >= LEN_W'(MAX_LINE));
   assign active   = !is_nl && (phase_ff != PH_LONG) && !too_long && (text_byte != CH_NUL);
   assign digit    = {8'd0, text_byte - CH_ZERO};
   assign st_now   = end_status(phase_ff);

   // next state
   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      acc_in   = acc_ff;
      unit_in  = unit_ff;
      len_in   = len_ff;
      if (is_nl) begin
         phase_in = PH_LEAD;
         esc_in   = 1'b0;
         acc_in   = '0;
         unit_in  = 1'b0;
         len_in   = '0;
      end else if (phase_ff != PH_LONG) begin
         len_in = len_inc;
         if (too_long) begin
            phase_in = PH_LONG;
            esc_in   = 1'b0;
         end else if (text_byte == CH_NUL) begin
            // content ends here; the status freezes unless the line grows too long
            esc_in = 1'b0;
            case (st_now)
               ST_ENTRY: phase_in = PH_TAIL;
               ST_BLANK: phase_in = PH_COMMENT;
               default:  phase_in = PH_ERR;
            endcase
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  if (text_byte == CH_HASH) phase_in = PH_COMMENT;
                  else if (text_byte == CH_QUOTE) phase_in = PH_PAT;
                  else if (!is_blank(text_byte)) phase_in = PH_ERR;
               end
               PH_PAT, PH_DESC: begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                  end else if (text_byte == CH_QUOTE) begin
                     phase_in = (phase_ff == PH_PAT) ? PH_AFTER_PAT : PH_TAIL;
                  end else if (text_byte == CH_BSLASH) begin
                     esc_in = 1'b1;
                  end
               end
               PH_AFTER_PAT: begin
                  if (is_digit(text_byte)) begin
                     acc_in   = digit;
                     phase_in = PH_NUM;
                  end else if (!is_blank(text_byte)) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM: begin
                  // times ten as two shifts, modulo 2^16
                  if (is_digit(text_byte)) acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
                  else if (is_blank(text_byte)) phase_in = PH_BEFORE_UNIT;
                  else phase_in = PH_ERR;
               end
               PH_BEFORE_UNIT: begin
                  if (text_byte == CH_UPPER_C || text_byte == CH_UPPER_F) begin
                     unit_in  = (text_byte == CH_UPPER_F);
                     phase_in = PH_UNIT_SEEN;
                  end else if (!is_blank(text_byte)) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_UNIT_SEEN: begin
                  phase_in = is_blank(text_byte) ? PH_BEFORE_DESC : PH_ERR;
               end
               PH_BEFORE_DESC: begin
                  if (text_byte == CH_QUOTE) phase_in = PH_DESC;
                  else if (!is_blank(text_byte)) phase_in = PH_ERR;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result
   always_comb begin
      res_valid              = 1'b0;
      res.kind               = KIND_PATTERN;
      res.string_byte        = text_byte;
      res.line_status        = ST_ENTRY;
      res.attr_number        = '0;
      res.unit_is_fahrenheit = 1'b0;
      if (is_nl) begin
         res_valid       = 1'b1;
         res.kind        = KIND_REPORT;
         res.string_byte = '0;
         res.line_status = st_now;
         if (st_now == ST_ENTRY) begin
            res.attr_number        = acc_ff;
            res.unit_is_fahrenheit = unit_ff;
         end
      end else if (active && (phase_ff == PH_PAT || phase_ff == PH_DESC)) begin
         res_valid = esc_ff || (text_byte != CH_QUOTE);
         res.kind  = (phase_ff == PH_PAT) ? KIND_PATTERN : KIND_DESC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         esc_ff   <= 1'b0;
         acc_ff   <= '0;
         unit_ff  <= 1'b0;
         len_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         acc_ff   <= acc_in;
         unit_ff  <= unit_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ===== rtl/core/dbp_out_reg.sv =====
module dbp_out_reg
   import dbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         take,
   output logic         full,
   output rsp_item_type item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign valid_in = load || (valid_ff && !take);
   assign full     = valid_ff;
   assign item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule
